FILE: rtl/ffaa_pkg.sv
// ----------------------------------------------------------------------------
// ffaa_pkg
// Shared constants and codes for the first-fit arena allocator.
// ----------------------------------------------------------------------------
package ffaa_pkg;

  localparam int GRANULE_BYTES     = 8;
  localparam int ARENA_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF  = 24;

  localparam int CFG_W    = 13;
  localparam int ACTION_W = 2;
  localparam int REQ_W    = 13;
  localparam int ADDR_W   = 12;
  localparam int STATUS_W = 3;
  localparam int NEED_W   = 11;
  localparam int AL_W     = 18;

  localparam logic [CFG_W-1:0] ARENA_BYTES_RST = 13'd4096;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_INIT    = 2'd2,
    ACT_DESTROY = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_INIT  = 3'd1,
    ST_NULL      = 3'd2,
    ST_NO_MEM    = 3'd3,
    ST_TOO_SMALL = 3'd4,
    ST_BAD_PTR   = 3'd5
  } status_t;

endpackage

FILE: rtl/ffaa_if.sv
// ----------------------------------------------------------------------------
// ffaa_req_if / ffaa_rsp_if
// Valid/ready channels carrying allocator requests and responses.
// ----------------------------------------------------------------------------
interface ffaa_req_if import ffaa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [REQ_W-1:0]    request_size;
  logic [ADDR_W-1:0]   address;

  modport source (output valid, action, request_size, address, input ready);
  modport sink   (input valid, action, request_size, address, output ready);
endinterface

interface ffaa_rsp_if import ffaa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   address_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, address_out, status, input ready);
  modport sink   (input valid, address_out, status, output ready);
endinterface

FILE: rtl/first_fit_arena_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_arena_allocator
// First-fit allocator over an implicit block list kept in a header memory.
// ----------------------------------------------------------------------------
// Requests arrive on req (action, request_size, address); each transaction
// yields exactly one response on rsp (address_out, status). cfg_we/cfg_data
// load the arena size used by the next init. One request is in flight at a
// time; req.ready is high only when the block is idle and the response
// register is empty, so a stalled rsp holds the block.
// Init and the rejects checked on the request itself respond straight from
// idle. Allocate visits one block header per step on the list, plus a split
// step when it splits. Free checks the header, merges forward with a read
// step and a check step per merge, and walks the list from the head to
// find the predecessor, one block per step, through the header memory's
// separate read and write ports.
// Reset and destroy both sweep the header memory, one entry a cycle
// (ARENA_BYTES/8 entries, 512 by default); no request is taken meanwhile.
// Destroy responds after its sweep.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator
  import ffaa_pkg::*;
#(
  parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  ffaa_req_if.sink         req,
  ffaa_rsp_if.source       rsp
);

  localparam int NGRAN    = ARENA_BYTES / GRANULE_BYTES;
  localparam int HDR_GRAN = (HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
  localparam int AW       = $clog2(NGRAN);
  localparam int SW       = AW;
  localparam int GW       = AW + 1;
  localparam int EW       = SW + 2;
  localparam int WW       = ((GW > NEED_W) ? GW : NEED_W) + 2;

  localparam logic [WW-1:0]   HDR_W   = WW'(HDR_GRAN);
  localparam logic [AL_W-1:0] CAP     = AL_W'(ARENA_BYTES) & ~AL_W'(7);
  localparam logic [AL_W-1:0] MIN_AL  = AL_W'(HDR_GRAN * GRANULE_BYTES + 8);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_A_CHK, S_A_SPLIT, S_F_CHK, S_MF_RD, S_MF_CHK, S_W_CHK
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  arena_size;
  logic              initialised;
  logic [GW-1:0]     arena_granules;
  logic [AW-1:0]     clr_idx;
  logic              clr_result;
  logic [AW-1:0]     cur;
  logic [AW-1:0]     base;
  logic [AW-1:0]     gpos;
  logic [AW-1:0]     nb;
  logic [SW-1:0]     bsize;
  logic              second;
  logic [NEED_W-1:0] need;
  logic [AW-1:0]     split_pos;
  logic [SW-1:0]     split_size;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;

  ffaa_hdr_ram #(.DEPTH(NGRAN), .WIDTH(EW)) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  function automatic logic [WW-1:0] sat_next(input logic [WW-1:0] sum,
                                             input logic [GW-1:0] lim);
    return (sum >= WW'(lim)) ? WW'(lim) : sum;
  endfunction

  logic              fire;
  logic              rd_start;
  logic              rd_free;
  logic [SW-1:0]     rd_size;
  logic [AL_W-1:0]   al_raw;
  logic [AL_W-1:0]   al;
  logic              too_small;
  logic [NEED_W-1:0] need_in;
  logic [WW-1:0]     g_in;
  logic              bad_ptr;
  logic [WW-1:0]     after_b;
  logic [WW-1:0]     after_r;
  logic              fit;
  logic [WW-1:0]     rem;
  logic              do_split;
  logic [WW-1:0]     ng;
  logic              mf_end;
  logic [ADDR_W-1:0] res_addr;

  assign fire      = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && !rsp.valid;

  assign rd_start = ram_rdata[SW+1];
  assign rd_free  = ram_rdata[SW];
  assign rd_size  = ram_rdata[SW-1:0];

  assign al_raw    = (AL_W'(arena_size) + AL_W'(7)) & ~AL_W'(7);
  assign al        = (al_raw > CAP) ? CAP : al_raw;
  assign too_small = al < MIN_AL;
  assign need_in   = NEED_W'((AL_W'(req.request_size) + AL_W'(7)) >> 3);
  assign g_in      = WW'(req.address[ADDR_W-1:3]) - HDR_W;
  assign bad_ptr   = (req.address[2:0] != 3'd0)
                  || (WW'(req.address[ADDR_W-1:3]) < HDR_W)
                  || (g_in >= WW'(arena_granules));

  assign after_b  = sat_next(WW'(base) + HDR_W + WW'(bsize), arena_granules);
  assign after_r  = sat_next(WW'(cur) + HDR_W + WW'(rd_size), arena_granules);
  assign fit      = rd_free && (WW'(rd_size) >= WW'(need));
  assign rem      = WW'(rd_size) - WW'(need);
  assign do_split = rem >= (HDR_W + WW'(1));
  assign ng       = WW'(cur) + HDR_W + WW'(need);
  assign mf_end   = ((state == S_MF_RD) && (after_b >= WW'(arena_granules)))
                 || ((state == S_MF_CHK) && !rd_free);
  assign res_addr = ADDR_W'((WW'(cur) + HDR_W) << 3);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
      end
      S_IDLE: begin
        ram_raddr = (req.action == ACT_FREE) ? AW'(g_in) : '0;
        if (fire && req.action == ACT_INIT && !initialised && !too_small) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, 1'b1, SW'((al >> 3) - AL_W'(HDR_GRAN))};
        end
      end
      S_A_CHK: begin
        ram_raddr = AW'(after_r);
        if (fit) begin
          ram_we    = 1'b1;
          ram_waddr = cur;
          ram_wdata = {1'b1, 1'b0, do_split ? SW'(need) : rd_size};
        end
      end
      S_A_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = split_pos;
        ram_wdata = {1'b1, 1'b1, split_size};
      end
      S_MF_RD: begin
        ram_raddr = AW'(after_b);
      end
      S_MF_CHK: begin
        ram_we    = 1'b1;
        ram_waddr = nb;
        ram_wdata = {1'b0, rd_free, rd_size};
      end
      S_W_CHK: begin
        ram_raddr = AW'(after_r);
        if (after_r == WW'(gpos) && rd_free) begin
          ram_we    = 1'b1;
          ram_waddr = gpos;
          ram_wdata = {1'b0, 1'b1, bsize};
        end
      end
      default: ;
    endcase
    if (mf_end) begin
      ram_we    = 1'b1;
      ram_waddr = base;
      ram_wdata = {1'b1, 1'b1, bsize};
      ram_raddr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLR;
      arena_size     <= ARENA_BYTES_RST;
      initialised    <= 1'b0;
      arena_granules <= '0;
      clr_idx        <= '0;
      clr_result     <= 1'b0;
      second         <= 1'b0;
      rsp.valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        arena_size <= cfg_data;
      end
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == AW'(NGRAN - 1)) begin
            state <= S_IDLE;
            if (clr_result) begin
              rsp.valid       <= 1'b1;
              rsp.address_out <= '0;
              rsp.status      <= ST_OK;
            end
          end
        end
        S_IDLE: begin
          if (fire) begin
            rsp.address_out <= '0;
            rsp.status      <= ST_OK;
            rsp.valid       <= 1'b1;
            if (req.action == ACT_INIT) begin
              if (!initialised) begin
                if (too_small) begin
                  rsp.status <= ST_TOO_SMALL;
                end else begin
                  initialised    <= 1'b1;
                  arena_granules <= GW'(al >> 3);
                end
              end
            end else if (req.action == ACT_DESTROY) begin
              rsp.valid      <= 1'b0;
              initialised    <= 1'b0;
              arena_granules <= '0;
              clr_idx        <= '0;
              clr_result     <= 1'b1;
              state          <= S_CLR;
            end else if (!initialised) begin
              rsp.status <= ST_NOT_INIT;
            end else if (req.action == ACT_ALLOC) begin
              if (req.request_size == '0) begin
                rsp.status <= ST_NULL;
              end else begin
                rsp.valid <= 1'b0;
                need      <= need_in;
                cur       <= '0;
                state     <= S_A_CHK;
              end
            end else begin
              if (req.address == '0) begin
                rsp.status <= ST_NULL;
              end else if (bad_ptr) begin
                rsp.status <= ST_BAD_PTR;
              end else begin
                rsp.valid <= 1'b0;
                gpos      <= AW'(g_in);
                state     <= S_F_CHK;
              end
            end
          end
        end
        S_A_CHK: begin
          if (fit) begin
            split_pos  <= AW'(ng);
            split_size <= SW'(rem - HDR_W);
            if (do_split && ng < WW'(NGRAN)) begin
              state <= S_A_SPLIT;
            end else begin
              rsp.valid       <= 1'b1;
              rsp.address_out <= res_addr;
              rsp.status      <= ST_OK;
              state           <= S_IDLE;
            end
          end else if (after_r >= WW'(arena_granules)) begin
            rsp.valid       <= 1'b1;
            rsp.address_out <= '0;
            rsp.status      <= ST_NO_MEM;
            state           <= S_IDLE;
          end else begin
            cur <= AW'(after_r);
          end
        end
        S_A_SPLIT: begin
          rsp.valid       <= 1'b1;
          rsp.address_out <= res_addr;
          rsp.status      <= ST_OK;
          state           <= S_IDLE;
        end
        S_F_CHK: begin
          if (!rd_start) begin
            rsp.valid       <= 1'b1;
            rsp.address_out <= '0;
            rsp.status      <= ST_BAD_PTR;
            state           <= S_IDLE;
          end else begin
            base   <= gpos;
            bsize  <= rd_size;
            second <= 1'b0;
            state  <= S_MF_RD;
          end
        end
        S_MF_RD: begin
          nb <= AW'(after_b);
          if (!mf_end) begin
            state <= S_MF_CHK;
          end
        end
        S_MF_CHK: begin
          if (rd_free) begin
            bsize <= SW'(WW'(bsize) + HDR_W + WW'(rd_size));
            state <= S_MF_RD;
          end
        end
        S_W_CHK: begin
          if (after_r == WW'(gpos)) begin
            if (rd_free) begin
              bsize  <= SW'(WW'(rd_size) + HDR_W + WW'(bsize));
              base   <= cur;
              second <= 1'b1;
              state  <= S_MF_RD;
            end else begin
              rsp.valid       <= 1'b1;
              rsp.address_out <= '0;
              rsp.status      <= ST_OK;
              state           <= S_IDLE;
            end
          end else if (after_r >= WW'(arena_granules)) begin
            rsp.valid       <= 1'b1;
            rsp.address_out <= '0;
            rsp.status      <= ST_OK;
            state           <= S_IDLE;
          end else begin
            cur <= AW'(after_r);
          end
        end
        default: state <= S_IDLE;
      endcase
      if (mf_end) begin
        if (second || gpos == '0) begin
          rsp.valid       <= 1'b1;
          rsp.address_out <= '0;
          rsp.status      <= ST_OK;
          state           <= S_IDLE;
        end else begin
          cur   <= '0;
          state <= S_W_CHK;
        end
      end
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    fire |=> !req.ready)
    else $error("request accepted while another is in flight");

  a_not_init: assert property (@(posedge clk) disable iff (rst)
    fire && !initialised && (req.action == ACT_ALLOC || req.action == ACT_FREE)
    |=> rsp.valid && rsp.status == ST_NOT_INIT)
    else $error("request on uninitialised arena not rejected");

  a_err_null: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.address_out == '0)
    else $error("error response carries an address");

  a_clr_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> !req.ready)
    else $error("request taken during header sweep");

endmodule

FILE: rtl/ffaa_hdr_ram.sv
// ----------------------------------------------------------------------------
// ffaa_hdr_ram
// Block header store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffaa_hdr_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
